@@ hdl/sfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the SLIP frame decoder with begin marker.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W = 3;

  typedef logic [BYTE_W-1:0] byte_t;

  // Decoder mode
  typedef enum logic [1:0] {
    MODE_HUNT  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2
  } mode_t;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    EV_DATA  = 2'd0,
    EV_START = 2'd1,
    EV_END   = 2'd2,
    EV_ERROR = 2'd3
  } event_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEGIN       = 3'd0,
    CFG_END         = 3'd1,
    CFG_ESCAPE      = 3'd2,
    CFG_ESC_BEGIN   = 3'd3,
    CFG_ESC_END     = 3'd4,
    CFG_ESC_ESCAPE  = 3'd5
  } cfg_idx_t;

  localparam byte_t RST_BEGIN      = 8'hC1;
  localparam byte_t RST_END        = 8'hC0;
  localparam byte_t RST_ESCAPE     = 8'hDB;
  localparam byte_t RST_ESC_BEGIN  = 8'hDE;
  localparam byte_t RST_ESC_END    = 8'hDC;
  localparam byte_t RST_ESC_ESCAPE = 8'hDD;

  typedef struct packed {
    byte_t begin_code;
    byte_t end_code;
    byte_t escape_code;
    byte_t escaped_begin_code;
    byte_t escaped_end_code;
    byte_t escaped_escape_code;
  } codes_t;

  typedef struct packed {
    event_t kind;
    byte_t  payload;
  } result_t;

endpackage

@@ hdl/sfd_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_in_if
// Receive byte channel: valid/ready handshake carrying one raw byte.
// ----------------------------------------------------------------------------
interface sfd_in_if
  import sfd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hdl/sfd_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_out_if
// Decoded event channel: valid/ready handshake carrying kind and byte.
// ----------------------------------------------------------------------------
interface sfd_out_if
  import sfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  byte_t             payload_byte;

  modport source (output valid, output event_kind, output payload_byte, input ready);
  modport sink   (input valid, input event_kind, input payload_byte, output ready);
endinterface

@@ hdl/sfd_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_cfg_regs
// Code value registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module sfd_cfg_regs
  import sfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  byte_t                cfg_wdata,
  output codes_t               codes
);

  codes_t codes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.begin_code          <= RST_BEGIN;
      codes_r.end_code            <= RST_END;
      codes_r.escape_code         <= RST_ESCAPE;
      codes_r.escaped_begin_code  <= RST_ESC_BEGIN;
      codes_r.escaped_end_code    <= RST_ESC_END;
      codes_r.escaped_escape_code <= RST_ESC_ESCAPE;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BEGIN:      codes_r.begin_code          <= cfg_wdata;
        CFG_END:        codes_r.end_code            <= cfg_wdata;
        CFG_ESCAPE:     codes_r.escape_code         <= cfg_wdata;
        CFG_ESC_BEGIN:  codes_r.escaped_begin_code  <= cfg_wdata;
        CFG_ESC_END:    codes_r.escaped_end_code    <= cfg_wdata;
        CFG_ESC_ESCAPE: codes_r.escaped_escape_code <= cfg_wdata;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign codes = codes_r;

endmodule

@@ hdl/sfd_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_core
// Input register, decode mode state machine and per-byte event decode.
// ----------------------------------------------------------------------------
module sfd_core
  import sfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  sfd_in_if.sink    in_ch,
  input  codes_t    codes,
  input  logic      out_free,
  output logic      push,
  output result_t   res
);

  logic   s1_valid_r, s1_valid_nxt;
  byte_t  s1_byte_r;
  mode_t  mode_r, mode_nxt;
  logic   emit;
  logic   s1_adv;
  logic   in_acc;

  // Byte in the input register leaves when it makes no event or the
  // result register can take its event.
  assign s1_adv      = s1_valid_r && (!emit || out_free);
  assign push        = s1_valid_r && emit && out_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // Next mode
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      MODE_FRAME: begin
        if (s1_byte_r == codes.end_code || s1_byte_r == codes.begin_code) begin
          mode_nxt = MODE_HUNT;
        end else if (s1_byte_r == codes.escape_code) begin
          mode_nxt = MODE_ESC;
        end
      end
      MODE_ESC: begin
        if (s1_byte_r == codes.escaped_begin_code ||
            s1_byte_r == codes.escaped_end_code ||
            s1_byte_r == codes.escaped_escape_code) begin
          mode_nxt = MODE_FRAME;
        end else begin
          mode_nxt = MODE_HUNT;
        end
      end
      default: begin
        mode_nxt = (s1_byte_r == codes.begin_code) ? MODE_FRAME : MODE_HUNT;
      end
    endcase
  end

  // Event for the byte in the input register; first match wins
  always_comb begin
    emit        = 1'b0;
    res.kind    = EV_DATA;
    res.payload = '0;
    case (mode_r)
      MODE_FRAME: begin
        if (s1_byte_r == codes.end_code) begin
          emit     = 1'b1;
          res.kind = EV_END;
        end else if (s1_byte_r == codes.begin_code) begin
          emit     = 1'b1;
          res.kind = EV_ERROR;
        end else if (s1_byte_r != codes.escape_code) begin
          emit        = 1'b1;
          res.payload = s1_byte_r;
        end
      end
      MODE_ESC: begin
        emit = 1'b1;
        if (s1_byte_r == codes.escaped_begin_code) begin
          res.payload = codes.begin_code;
        end else if (s1_byte_r == codes.escaped_end_code) begin
          res.payload = codes.end_code;
        end else if (s1_byte_r == codes.escaped_escape_code) begin
          res.payload = codes.escape_code;
        end else begin
          res.kind = EV_ERROR;
        end
      end
      default: begin
        if (s1_byte_r == codes.begin_code) begin
          emit     = 1'b1;
          res.kind = EV_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mode_r     <= MODE_HUNT;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_adv) begin
        mode_r <= mode_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // Mode only moves when a word leaves the input register
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(mode_r))
    else $error("decode mode changed without a word advancing");

  // Any framing error sends the decoder back to hunting
  a_err_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit && res.kind == EV_ERROR |=> mode_r == MODE_HUNT)
    else $error("framing error did not return to hunting");

  // A frame start is only reported while hunting and leads into a frame
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit && res.kind == EV_START |=> mode_r == MODE_FRAME)
    else $error("frame start did not enter frame mode");

  // Held word is not overwritten by a new one while it is stuck
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |-> !in_acc)
    else $error("input register overrun");

endmodule

@@ hdl/sfd_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_out_reg
// Result register driving the event channel.
// ----------------------------------------------------------------------------
module sfd_out_reg
  import sfd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  result_t   res,
  output logic      out_free,
  sfd_out_if.source out_ch
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    if (push) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.event_kind   = res_r.kind;
  assign out_ch.payload_byte = res_r.payload;

endmodule

@@ hdl/slip_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slip_frame_decoder
// SLIP receive decoder with begin and end frame markers.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  - one raw received byte per word (valid/ready).
//   out_ch - decoded events: event_kind 0 data byte, 1 frame start,
//            2 frame end, 3 framing error; payload_byte is the data byte
//            for kind 0 and zero otherwise. Escape bytes and bytes dropped
//            while hunting produce no word.
//   cfg_*  - write-only code registers (index 0 begin, 1 end, 2 escape,
//            3..5 escaped begin/end/escape). Write only while idle.
// An accepted byte passes through the input register, where the mode machine
// decodes it, and then the result register before its event is on out_ch.
// Throughput is one byte per cycle while out_ch does not stall; the single
// mode register is the only state carried from byte to byte.
// Reset puts the decoder in hunting mode, empties both registers and loads
// the standard code values. When out_ch stalls the result register holds,
// the input register still takes one more byte, and in_ch.ready drops once
// a byte with an event is waiting behind the held result.
// ----------------------------------------------------------------------------
module slip_frame_decoder
  import sfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  sfd_in_if.sink               in_ch,
  sfd_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  byte_t                cfg_wdata
);

  codes_t  codes;
  logic    out_free;
  logic    push;
  result_t res;

  sfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .codes     (codes)
  );

  sfd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .codes    (codes),
    .out_free (out_free),
    .push     (push),
    .res      (res)
  );

  sfd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for slip_frame_decoder. A directed table walks the
// hunting, frame, escape and error paths under the reset code values. Random
// framed traffic with noise then runs under several code settings, including
// all-equal and overlapping codes. Every decoded word is compared in order
// against the directed table or a byte-level decoder model in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import sfd_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_CYCLES  = 4;
  localparam int NUM_SETTINGS  = 6;
  localparam int ITEMS_PER_SET = 325;
  localparam int HOLD_CYCLES   = 80;
  localparam int MAX_REPORTS   = 10;

  // indexes with no register behind them; writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    byte_t  rx;
    bit     typed;
    bit     has_ev;
    event_t kind;
    byte_t  pay;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  byte_t                cfg_wdata;

  sfd_in_if  in_ch();
  sfd_out_if out_ch();

  slip_frame_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // bench copy of the decoder
  mode_t   rx_mode;
  codes_t  codes;
  result_t expected_events[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int cycle_count;
  int mismatches;
  int bytes_sent;
  int framed_bytes;
  int kind_seen[4];

  // directed walk under reset codes; untyped rows take the model's answer
  stim_row_t directed_rows[24] = '{
    '{8'h00,          1'b1, 1'b0, EV_DATA,  8'h00},  // dropped while hunting
    '{RST_END,        1'b1, 1'b0, EV_DATA,  8'h00},  // end code while hunting
    '{8'hFF,          1'b1, 1'b0, EV_DATA,  8'h00},
    '{RST_BEGIN,      1'b1, 1'b1, EV_START, 8'h00},
    '{8'h00,          1'b1, 1'b1, EV_DATA,  8'h00},
    '{8'hFF,          1'b1, 1'b1, EV_DATA,  8'hFF},
    '{RST_ESCAPE,     1'b1, 1'b0, EV_DATA,  8'h00},
    '{RST_ESC_BEGIN,  1'b0, 1'b0, EV_DATA,  8'h00},
    '{RST_ESCAPE,     1'b1, 1'b0, EV_DATA,  8'h00},
    '{RST_ESC_END,    1'b0, 1'b0, EV_DATA,  8'h00},
    '{RST_ESCAPE,     1'b1, 1'b0, EV_DATA,  8'h00},
    '{RST_ESC_ESCAPE, 1'b0, 1'b0, EV_DATA,  8'h00},
    '{RST_END,        1'b1, 1'b1, EV_END,   8'h00},
    '{RST_BEGIN,      1'b1, 1'b1, EV_START, 8'h00},
    '{RST_BEGIN,      1'b1, 1'b1, EV_ERROR, 8'h00},  // stray begin
    '{RST_BEGIN,      1'b1, 1'b1, EV_START, 8'h00},
    '{RST_ESCAPE,     1'b1, 1'b0, EV_DATA,  8'h00},
    '{8'h55,          1'b1, 1'b1, EV_ERROR, 8'h00},  // unknown escape pair
    '{RST_BEGIN,      1'b1, 1'b1, EV_START, 8'h00},
    '{RST_ESCAPE,     1'b1, 1'b0, EV_DATA,  8'h00},
    '{RST_END,        1'b1, 1'b1, EV_ERROR, 8'h00},  // end code after escape
    '{RST_BEGIN,      1'b1, 1'b1, EV_START, 8'h00},
    '{RST_ESCAPE,     1'b1, 1'b0, EV_DATA,  8'h00},
    '{RST_BEGIN,      1'b1, 1'b1, EV_ERROR, 8'h00}   // begin code after escape
  };

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_events.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // decode one byte; returns 1 when the byte produces an event word
  function automatic bit decode_byte(input byte_t b, output result_t ev);
    ev = '{kind: EV_DATA, payload: 8'h00};
    case (rx_mode)
      MODE_FRAME: begin
        if (b == codes.end_code) begin
          rx_mode = MODE_HUNT;
          ev.kind = EV_END;
        end else if (b == codes.begin_code) begin
          rx_mode = MODE_HUNT;
          ev.kind = EV_ERROR;
        end else if (b == codes.escape_code) begin
          rx_mode = MODE_ESC;
          return 1'b0;
        end else begin
          ev.payload = b;
        end
        return 1'b1;
      end
      MODE_ESC: begin
        rx_mode = MODE_FRAME;
        if (b == codes.escaped_begin_code) begin
          ev.payload = codes.begin_code;
        end else if (b == codes.escaped_end_code) begin
          ev.payload = codes.end_code;
        end else if (b == codes.escaped_escape_code) begin
          ev.payload = codes.escape_code;
        end else begin
          rx_mode = MODE_HUNT;
          ev.kind = EV_ERROR;
        end
        return 1'b1;
      end
      default: begin
        if (b == codes.begin_code) begin
          rx_mode = MODE_FRAME;
          ev.kind = EV_START;
          return 1'b1;
        end
        rx_mode = MODE_HUNT;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic codes_t pick_codes(input int setting);
    codes_t c;
    c.begin_code          = byte_t'($urandom);
    c.end_code            = byte_t'($urandom);
    c.escape_code         = byte_t'($urandom);
    c.escaped_begin_code  = byte_t'($urandom);
    c.escaped_end_code    = byte_t'($urandom);
    c.escaped_escape_code = byte_t'($urandom);
    case (setting)
      0: c = '{RST_BEGIN, RST_END, RST_ESCAPE, RST_ESC_BEGIN, RST_ESC_END, RST_ESC_ESCAPE};
      1: c = '0;
      2: c = '1;
      3: begin
        // begin equals end, all three escape seconds equal
        c.end_code           = c.begin_code;
        c.escaped_end_code   = c.escaped_begin_code;
        c.escaped_escape_code = c.escaped_begin_code;
      end
      4: begin
        c.escape_code      = c.begin_code;
        c.escaped_end_code = c.escaped_escape_code;
      end
      default: ;
    endcase
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input byte_t b, input bit fixed = 1'b0,
                           input bit fixed_has = 1'b0, input result_t fixed_res = '0);
    result_t ev;
    bit      has;
    mode_t   prev_mode;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= byte_t'($urandom);
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    prev_mode = rx_mode;
    has = decode_byte(b, ev);
    if (fixed) begin
      has = fixed_has;
      ev  = fixed_res;
    end
    if (has) expected_events.push_back(ev);
    bytes_sent++;
    if (has || prev_mode != MODE_HUNT) framed_bytes++;
    @(negedge clk);
  endtask

  // one random unit: mostly a well-formed frame, sometimes line noise
  task automatic send_frame();
    int pick;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(byte_t'($urandom));
    end else begin
      send_byte(codes.begin_code);
      repeat ($urandom_range(0, 10)) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_byte(byte_t'($urandom));
        end else if (pick < 90) begin
          send_byte(codes.escape_code);
          case ($urandom_range(0, 2))
            0:       send_byte(codes.escaped_begin_code);
            1:       send_byte(codes.escaped_end_code);
            default: send_byte(codes.escaped_escape_code);
          endcase
        end else if (pick < 96) begin
          send_byte(codes.escape_code);
          send_byte(byte_t'($urandom));
        end else begin
          send_byte(codes.begin_code);
        end
      end
      if ($urandom_range(0, 99) < 85) send_byte(codes.end_code);
    end
  endtask

  // entered at a falling edge with valid already dropped
  task automatic wait_drained();
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic program_codes(input codes_t c);
    write_reg(CFG_BEGIN,      c.begin_code);
    write_reg(CFG_END,        c.end_code);
    write_reg(CFG_ESCAPE,     c.escape_code);
    write_reg(CFG_ESC_BEGIN,  c.escaped_begin_code);
    write_reg(CFG_ESC_END,    c.escaped_end_code);
    write_reg(CFG_ESC_ESCAPE, c.escaped_escape_code);
    write_reg(CFG_SPARE_LO,   byte_t'($urandom));
    write_reg(CFG_SPARE_HI,   byte_t'($urandom));
    cfg_we <= 1'b0;
    codes = c;
  endtask

  // result sink: random back-pressure plus an occasional long hold
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("cycle %0d: unexpected word kind %0d byte %02h", cycle_count,
                   out_ch.event_kind, out_ch.payload_byte);
      end else begin
        want = expected_events.pop_front();
        kind_seen[want.kind]++;
        if (out_ch.event_kind !== want.kind || out_ch.payload_byte !== want.payload) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("cycle %0d: expected %s byte %02h, got kind %0d byte %02h",
                     cycle_count, want.kind.name(), want.payload,
                     out_ch.event_kind, out_ch.payload_byte);
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    int        target;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_BEGIN;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    hold_left     = 0;
    cycle_count   = 0;
    mismatches    = 0;
    bytes_sent    = 0;
    framed_bytes  = 0;
    send_idle_pct = 14;
    recv_idle_pct = 62;
    rx_mode       = MODE_HUNT;
    codes         = pick_codes(0);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_byte(row.rx, row.typed, row.has_ev, result_t'{row.kind, row.pay});
    end
    in_ch.valid <= 1'b0;
    wait_drained();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      // idle pattern: sender light / sink heavy, then swapped, then none
      case (s / 2)
        0: begin send_idle_pct = 14; recv_idle_pct = 62; end
        1: begin send_idle_pct = 62; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      program_codes(pick_codes(s));
      // the decoder restarts from hunting only if the stream says so
      if (s == 0 || s == 4) hold_left = HOLD_CYCLES;
      target = bytes_sent + ITEMS_PER_SET;
      while (bytes_sent < target - ITEMS_PER_SET / 2) send_frame();
      // pause the sender until every word is back
      in_ch.valid <= 1'b0;
      wait_drained();
      while (bytes_sent < target) send_frame();
      in_ch.valid <= 1'b0;
      wait_drained();
    end

    $display("sent %0d bytes (%0d inside frames) over %0d code settings",
             bytes_sent, framed_bytes, NUM_SETTINGS);
    $display("checked words: data %0d, start %0d, end %0d, error %0d; mismatches %0d",
             kind_seen[EV_DATA], kind_seen[EV_START], kind_seen[EV_END],
             kind_seen[EV_ERROR], mismatches);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/sfd_pkg.sv
hdl/sfd_in_if.sv
hdl/sfd_out_if.sv
hdl/sfd_cfg_regs.sv
hdl/sfd_core.sv
hdl/sfd_out_reg.sv
hdl/slip_frame_decoder.sv
bench/tb_top.sv
